// ===== src/shsr_pkg.sv =====
package shsr_pkg;

    localparam int ACTION_W = 2;
    localparam int LEVEL_W  = 4;
    localparam int NUM_W    = 18;
    localparam int IDLE_W   = 16;
    localparam int SPL_W    = 7;
    localparam int SPEED_W  = 10;
    localparam int PHASE_W  = 3;
    localparam int COIL_W   = 4;
    localparam int CMP_W    = 16;
    localparam int GOAL_W   = LEVEL_W + SPL_W;
    localparam int CNT_W    = $clog2(NUM_W + 1);
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [NUM_W-1:0]   NUMER_RESET   = NUM_W'(54930);
    localparam logic [IDLE_W-1:0]  IDLE_RESET    = IDLE_W'(65500);
    localparam logic [SPL_W-1:0]   SPL_RESET     = SPL_W'(30);
    localparam logic [CMP_W-1:0]   COMPARE_RESET = CMP_W'(65000);
    localparam logic [SPEED_W-1:0] SPEED_MAX     = {SPEED_W{1'b1}};
    localparam logic [PHASE_W-1:0] PHASE_RAMP    = {PHASE_W{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_LEVEL = 2'd1,
        ACT_DIR   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        REG_NUMER = 2'd0,
        REG_IDLE  = 2'd1,
        REG_SPL   = 2'd2
    } t_reg_idx;

    // Half-step coil energizing sequence
    function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] ph);
        logic [COIL_W-1:0] pat;
        case (ph)
            3'd0:    pat = 4'd1;
            3'd1:    pat = 4'd3;
            3'd2:    pat = 4'd2;
            3'd3:    pat = 4'd6;
            3'd4:    pat = 4'd4;
            3'd5:    pat = 4'd12;
            3'd6:    pat = 4'd8;
            default: pat = 4'd9;
        endcase
        return pat;
    endfunction

endpackage

// ===== src/stepper_half_step_ramp_controller.sv =====
// Half-step stepper controller with speed ramp. Each request is a tick (timer
// compare event), a new target speed level, or a direction request, and each
// gives exactly one result. A tick divides the interval numerator by the
// current speed (tenths of an RPM) in a restoring divider that retires one
// quotient bit per cycle. A tick runs 18 divider steps; the sequencer then
// sees completion and moves to its write state, where it commits the result
// into the output register once the slot is free of a stalled result.
// Level and direction requests go from idle straight to the write state.
// The block holds o_in_stall high while a request is in flight; a finished
// result sits in the output register, so the next request is accepted while
// it waits to be taken. The interval clamps to idle_interval at zero speed or
// when the quotient reaches it; a pending reversal takes effect only at that
// standstill. When a step lands on phase 7 the speed moves one tenth toward
// level * speed_per_level (down while a reversal waits), saturating at 0 and
// 1023. Registers sit on an APB-style port at byte addresses 0, 4 and 8:
// interval_numerator, idle_interval, speed_per_level; write them only while
// the block is idle.
module stepper_half_step_ramp_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [shsr_pkg::ACTION_W-1:0] i_action,
    input  logic [shsr_pkg::LEVEL_W-1:0]  i_speed_level,
    input  logic                          i_wanted_direction,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [shsr_pkg::COIL_W-1:0]   o_coils,
    output logic [shsr_pkg::PHASE_W-1:0]  o_phase,
    output logic [shsr_pkg::IDLE_W-1:0]   o_interval,
    output logic [shsr_pkg::CMP_W-1:0]    o_next_compare,
    output logic [shsr_pkg::SPEED_W-1:0]  o_speed_tenths,
    output logic                          o_current_direction,
    output logic                          o_reversal_pending,
    output logic                          o_stepped,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shsr_pkg::ADDR_W-1:0]   paddr,
    input  logic [shsr_pkg::DATA_W-1:0]   pwdata,
    output logic [shsr_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import shsr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DIV   = 3'b010,
        ST_WRITE = 3'b100
    } t_state;

    // Configuration registers
    logic [NUM_W-1:0]   r_numer;
    logic [IDLE_W-1:0]  r_idle;
    logic [SPL_W-1:0]   r_spl;

    // Motor state
    logic [PHASE_W-1:0] r_phase;
    logic [LEVEL_W-1:0] r_target;
    logic [SPEED_W-1:0] r_speed;
    logic               r_dir;
    logic               r_pend;
    logic [CMP_W-1:0]   r_compare;

    // Sequencer and latched request
    t_state             r_state;
    t_state             n_state;
    logic [ACTION_W-1:0] r_act;
    logic [LEVEL_W-1:0] r_level;
    logic               r_want;

    // Result register
    logic               r_out_valid;
    logic [COIL_W-1:0]  r_o_coils;
    logic [PHASE_W-1:0] r_o_phase;
    logic [IDLE_W-1:0]  r_o_interval;
    logic [CMP_W-1:0]   r_o_compare;
    logic [SPEED_W-1:0] r_o_speed;
    logic               r_o_dir;
    logic               r_o_pend;
    logic               r_o_stepped;

    logic               in_acc;
    logic               out_free;
    logic               commit;
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_quo;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;

    // Next motor state and result fields
    logic [PHASE_W-1:0] n_phase;
    logic [LEVEL_W-1:0] n_target;
    logic [SPEED_W-1:0] n_speed;
    logic               n_dir;
    logic               n_pend;
    logic [CMP_W-1:0]   n_compare;
    logic [IDLE_W-1:0]  n_interval;
    logic               n_stepped;
    logic               standstill;
    logic [GOAL_W-1:0]  goal;

    assign pready     = 1'b1;
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign commit     = (r_state == ST_WRITE) && out_free;
    assign div_start  = in_acc && (t_action'(i_action) == ACT_TICK);

    shsr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_numer),
        .i_divisor  (r_speed),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Configuration access
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_numer <= NUMER_RESET;
            r_idle  <= IDLE_RESET;
            r_spl   <= SPL_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_NUMER: r_numer <= pwdata[NUM_W-1:0];
                REG_IDLE:  r_idle  <= pwdata[IDLE_W-1:0];
                REG_SPL:   r_spl   <= pwdata[SPL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_NUMER: prdata = DATA_W'(r_numer);
            REG_IDLE:  prdata = DATA_W'(r_idle);
            REG_SPL:   prdata = DATA_W'(r_spl);
            default:   prdata = '0;
        endcase
    end

    // Sequencer: accept, divide on ticks, commit once the result slot is free
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc)
                    n_state = div_start ? ST_DIV : ST_WRITE;
            end
            ST_DIV: begin
                if (div_done)
                    n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free)
                    n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= ST_IDLE;
        else
            r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act   <= i_action;
            r_level <= i_speed_level;
            r_want  <= i_wanted_direction;
        end
    end

    // Commit arithmetic: clamp, reversal, compare advance, step, ramp
    always_comb begin
        n_phase    = r_phase;
        n_target   = r_target;
        n_speed    = r_speed;
        n_dir      = r_dir;
        n_pend     = r_pend;
        n_compare  = r_compare;
        n_interval = '0;
        n_stepped  = 1'b0;
        standstill = (r_speed == '0) || (div_quo >= NUM_W'(r_idle));
        goal       = GOAL_W'(r_target) * GOAL_W'(r_spl);
        case (t_action'(r_act))
            ACT_TICK: begin
                n_interval = standstill ? r_idle : div_quo[IDLE_W-1:0];
                if (standstill && r_pend) begin
                    n_pend = 1'b0;
                    n_dir  = !r_dir;
                end
                n_compare = r_compare + n_interval;
                n_stepped = !((n_interval == r_idle) && (r_target == '0));
                if (n_stepped) begin
                    n_phase = n_dir ? (r_phase - PHASE_W'(1)) : (r_phase + PHASE_W'(1));
                    if (n_phase == PHASE_RAMP) begin
                        if (!n_pend && (GOAL_W'(r_speed) < goal)) begin
                            if (r_speed != SPEED_MAX)
                                n_speed = r_speed + SPEED_W'(1);
                        end else if (n_pend || (GOAL_W'(r_speed) > goal)) begin
                            if (r_speed != '0)
                                n_speed = r_speed - SPEED_W'(1);
                        end
                    end
                end
            end
            ACT_LEVEL: n_target = r_level;
            ACT_DIR: begin
                if (r_want != r_dir)
                    n_pend = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_target  <= '0;
            r_speed   <= '0;
            r_dir     <= 1'b0;
            r_pend    <= 1'b0;
            r_compare <= COMPARE_RESET;
        end else if (commit) begin
            r_phase   <= n_phase;
            r_target  <= n_target;
            r_speed   <= n_speed;
            r_dir     <= n_dir;
            r_pend    <= n_pend;
            r_compare <= n_compare;
        end
    end

    // Result register: load on commit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (commit)
            r_out_valid <= 1'b1;
        else if (!i_out_stall)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_o_coils    <= coil_pattern(n_phase);
            r_o_phase    <= n_phase;
            r_o_interval <= n_interval;
            r_o_compare  <= n_compare;
            r_o_speed    <= n_speed;
            r_o_dir      <= n_dir;
            r_o_pend     <= n_pend;
            r_o_stepped  <= n_stepped;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_coils             = r_o_coils;
    assign o_phase             = r_o_phase;
    assign o_interval          = r_o_interval;
    assign o_next_compare      = r_o_compare;
    assign o_speed_tenths      = r_o_speed;
    assign o_current_direction = r_o_dir;
    assign o_reversal_pending  = r_o_pend;
    assign o_stepped           = r_o_stepped;

`ifndef SYNTH
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> ((r_state == ST_DIV) || (r_state == ST_WRITE)))
        else $error("accepted request did not leave idle");

    a_speed_ramp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_speed != $past(r_speed)) |->
            ((SPEED_W'(r_speed - $past(r_speed)) == SPEED_W'(1)) ||
             (SPEED_W'($past(r_speed) - r_speed) == SPEED_W'(1))))
        else $error("speed moved by more than one tenth");

    a_reverse_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dir != $past(r_dir)) |-> $fell(r_pend))
        else $error("direction changed without a pending reversal");
`endif

endmodule

// ===== src/shsr_div.sv =====
module shsr_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [shsr_pkg::NUM_W-1:0]   i_dividend,
    input  logic [shsr_pkg::SPEED_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [shsr_pkg::NUM_W-1:0]   o_quotient
);
    import shsr_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [SPEED_W-1:0] r_rem;
    logic [NUM_W-1:0]   r_quo;

    logic [SPEED_W:0]   trial;
    logic [SPEED_W:0]   diff;
    logic               fits;
    logic [SPEED_W-1:0] n_rem;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        fits  = trial >= {1'b0, i_divisor};
        diff  = trial - {1'b0, i_divisor};
        n_rem = fits ? diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
